[rtl/mmd_pkg.sv]
package mmd_pkg;

  localparam int unsigned ATOM_MAX    = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned SQ_W        = 2 * DIST_W;
  localparam int unsigned ROW_W       = 37;
  localparam int unsigned TOT_W       = 41;
  localparam int unsigned VAL_W       = 36;
  localparam int unsigned NSQ_W       = 11;
  localparam int unsigned PAIR_COUNT  = (ATOM_MAX * (ATOM_MAX - 1)) / 2;
  localparam int unsigned SLOT_W      = $clog2(PAIR_COUNT);
  localparam int unsigned DCNT_W      = $clog2(TOT_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_READ      = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [CNT_W-1:0] ATOM_RESET = CNT_W'(ATOM_MAX);
  localparam logic [CNT_W-1:0] ATOM_FLOOR = CNT_W'(2);
  localparam logic [CNT_W-1:0] ATOM_CEIL  = CNT_W'(ATOM_MAX);

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_READ_BAD
  } kind_e;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] metric_value;
    logic                    status;
  } res_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic              diag;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] distance;
  } cls_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (n < ATOM_FLOOR) begin
      n = ATOM_FLOOR;
    end
    if (n > ATOM_CEIL) begin
      n = ATOM_CEIL;
    end
    return n;
  endfunction

  // packed slot of unordered pair lo < hi
  function automatic logic [SLOT_W-1:0] pair_slot(input logic [IDX_W-1:0] lo,
                                                  input logic [IDX_W-1:0] hi);
    logic [IDX_W-1:0]   hm1;
    logic [2*IDX_W-1:0] prod;
    hm1  = hi - 1'b1;
    prod = {{IDX_W{1'b0}}, hi} * {{IDX_W{1'b0}}, hm1};
    return SLOT_W'(prod >> 1) + SLOT_W'(lo);
  endfunction

endpackage

[rtl/mmd_front.sv]
module mmd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  mmd_pkg::cmd_t               cmd_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mmd_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        q_full_i,
  input  logic                        clearing_i,
  output logic                        push_o,
  output mmd_pkg::cls_t               cls_o,
  output logic [mmd_pkg::CNT_W-1:0]   n_o
);

  logic [mmd_pkg::CNT_W-1:0] atom_count_q;
  logic [mmd_pkg::CNT_W-1:0] n;
  logic [mmd_pkg::IDX_W-1:0] lo;
  logic [mmd_pkg::IDX_W-1:0] hi;
  logic                      in_range;
  logic                      diag;
  logic                      keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= mmd_pkg::ATOM_RESET;
    end else if (cfg_valid_i) begin
      atom_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    n        = mmd_pkg::eff_count(atom_count_q);
    in_range = ({1'b0, cmd_i.first_index} < n) && ({1'b0, cmd_i.second_index} < n);
    diag     = (cmd_i.first_index == cmd_i.second_index);
    if (cmd_i.first_index < cmd_i.second_index) begin
      lo = cmd_i.first_index;
      hi = cmd_i.second_index;
    end else begin
      lo = cmd_i.second_index;
      hi = cmd_i.first_index;
    end

    cls_o.diag     = diag;
    cls_o.lo       = lo;
    cls_o.hi       = hi;
    cls_o.distance = cmd_i.distance;
    cls_o.slot     = diag ? '0 : mmd_pkg::pair_slot(lo, hi);
    if (cmd_i.operation == mmd_pkg::OP_WRITE) begin
      cls_o.kind = mmd_pkg::KIND_WRITE;
    end else if (in_range) begin
      cls_o.kind = mmd_pkg::KIND_READ;
    end else begin
      cls_o.kind = mmd_pkg::KIND_READ_BAD;
    end

    // drop writes to the diagonal or beyond n
    keep   = (cmd_i.operation == mmd_pkg::OP_READ) || (in_range && !diag);
    busy_o = q_full_i | clearing_i;
    push_o = start_i & ~busy_o & keep;
  end

  assign n_o = n;

endmodule

[rtl/mmd_queue.sv]
module mmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mmd_pkg::cls_t data_i,
  input  logic          pop_i,
  output mmd_pkg::cls_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  mmd_pkg::cls_t              entries_q [mmd_pkg::QUEUE_DEPTH];
  logic [mmd_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [mmd_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [mmd_pkg::QCNT_W-1:0] count_q;

  assign full_o  = (count_q == mmd_pkg::QCNT_W'(mmd_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/mmd_div.sv]
module mmd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mmd_pkg::TOT_W-1:0] dividend_i,
  input  logic [mmd_pkg::NSQ_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [mmd_pkg::TOT_W-1:0] quotient_o
);

  logic                       run_q;
  logic                       done_q;
  logic [mmd_pkg::DCNT_W-1:0] cnt_q;
  logic [mmd_pkg::NSQ_W-1:0]  rem_q;
  logic [mmd_pkg::NSQ_W-1:0]  dvs_q;
  logic [mmd_pkg::TOT_W-1:0]  dq_q;
  logic [mmd_pkg::NSQ_W:0]    trial;
  logic [mmd_pkg::NSQ_W:0]    diff;
  logic                       ge;

  always_comb begin
    trial = {rem_q, dq_q[mmd_pkg::TOT_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= mmd_pkg::DCNT_W'(mmd_pkg::TOT_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mmd_pkg::DCNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[mmd_pkg::NSQ_W-1:0] : trial[mmd_pkg::NSQ_W-1:0];
      dq_q  <= {dq_q[mmd_pkg::TOT_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

[rtl/mmd_back.sv]
module mmd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mmd_pkg::CNT_W-1:0] n_i,
  input  logic                      q_empty_i,
  input  mmd_pkg::cls_t             q_data_i,
  output logic                      q_pop_o,
  output logic                      clearing_o,
  output logic                      result_valid_o,
  output mmd_pkg::res_t             result_o
);

  localparam int unsigned DIF_W = mmd_pkg::TOT_W + 1;
  localparam int unsigned SUM_W = mmd_pkg::TOT_W + 3;
  localparam logic signed [SUM_W-1:0] VMAX =
    {{(SUM_W - mmd_pkg::VAL_W + 1){1'b0}}, {(mmd_pkg::VAL_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN =
    {{(SUM_W - mmd_pkg::VAL_W + 1){1'b1}}, {(mmd_pkg::VAL_W - 1){1'b0}}};

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_W1    = 4'd2;
  localparam logic [3:0] S_W2    = 4'd3;
  localparam logic [3:0] S_W3    = 4'd4;
  localparam logic [3:0] S_R1    = 4'd5;
  localparam logic [3:0] S_R2    = 4'd6;
  localparam logic [3:0] S_DT    = 4'd7;
  localparam logic [3:0] S_DL    = 4'd8;
  localparam logic [3:0] S_DH    = 4'd9;
  localparam logic [3:0] S_F1    = 4'd10;
  localparam logic [3:0] S_F2    = 4'd11;
  localparam logic [3:0] S_F3    = 4'd12;

  // memories
  logic [mmd_pkg::DIST_W-1:0] dist_mem [mmd_pkg::PAIR_COUNT];
  logic [mmd_pkg::ROW_W-1:0]  row_mem  [mmd_pkg::ATOM_MAX];
  logic [mmd_pkg::DIST_W-1:0] dist_rd_q;
  logic [mmd_pkg::ROW_W-1:0]  row_rd_q;
  logic                       dist_we, dist_re, row_we, row_re;
  logic [mmd_pkg::SLOT_W-1:0] dist_waddr, dist_raddr;
  logic [mmd_pkg::DIST_W-1:0] dist_wdata;
  logic [mmd_pkg::IDX_W-1:0]  row_waddr, row_raddr;
  logic [mmd_pkg::ROW_W-1:0]  row_wdata;

  // control
  logic [3:0]                 state_q, state_d;
  logic [mmd_pkg::SLOT_W-1:0] clr_q, clr_d;
  logic [mmd_pkg::TOT_W-1:0]  total_q, total_d;
  logic                       res_valid_q, res_valid_d;

  // payload
  mmd_pkg::cls_t              cur_q, cur_d;
  mmd_pkg::res_t              res_q, res_d;
  logic [mmd_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic [mmd_pkg::SQ_W-1:0]   new_sq_q, new_sq_d;
  logic [mmd_pkg::ROW_W-1:0]  row_lo_q, row_lo_d;
  logic [mmd_pkg::ROW_W-1:0]  row_hi_q, row_hi_d;
  logic [mmd_pkg::TOT_W-1:0]  qt_q, qt_d, ql_q, ql_d, qh_q, qh_d;
  logic signed [DIF_W-1:0]    di_q, di_d, dj_q, dj_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;

  // divider
  logic                       div_start, div_done;
  logic [mmd_pkg::TOT_W-1:0]  div_dividend, div_quot;
  logic [mmd_pkg::NSQ_W-1:0]  div_divisor;

  logic [2*mmd_pkg::CNT_W-1:0] nprod;
  logic [mmd_pkg::NSQ_W-1:0]   nsq;
  logic [mmd_pkg::NSQ_W-1:0]   n_ext;
  logic signed [SUM_W-1:0]     di_ext, dj_ext, sq_ext, half;

  mmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    nprod  = {{mmd_pkg::CNT_W{1'b0}}, n_i} * {{mmd_pkg::CNT_W{1'b0}}, n_i};
    nsq    = nprod[mmd_pkg::NSQ_W-1:0];
    n_ext  = {{(mmd_pkg::NSQ_W - mmd_pkg::CNT_W){1'b0}}, n_i};
    di_ext = $signed({{(SUM_W - DIF_W){di_q[DIF_W-1]}}, di_q});
    dj_ext = $signed({{(SUM_W - DIF_W){dj_q[DIF_W-1]}}, dj_q});
    sq_ext = $signed({{(SUM_W - mmd_pkg::SQ_W){1'b0}}, sq_q});
    // halve toward zero off the diagonal; on the diagonal the sum passes unchanged
    half   = cur_q.diag ? sum_q
           : (sum_q + $signed({{(SUM_W - 1){1'b0}}, sum_q[SUM_W-1]})) >>> 1;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    total_d      = total_q;
    res_valid_d  = 1'b0;
    cur_d        = cur_q;
    res_d        = res_q;
    sq_d         = sq_q;
    new_sq_d     = new_sq_q;
    row_lo_d     = row_lo_q;
    row_hi_d     = row_hi_q;
    qt_d         = qt_q;
    ql_d         = ql_q;
    qh_d         = qh_q;
    di_d         = di_q;
    dj_d         = dj_q;
    sum_d        = sum_q;
    q_pop_o      = 1'b0;
    dist_we      = 1'b0;
    dist_re      = 1'b0;
    dist_waddr   = cur_q.slot;
    dist_raddr   = q_data_i.slot;
    dist_wdata   = cur_q.distance;
    row_we       = 1'b0;
    row_re       = 1'b0;
    row_waddr    = cur_q.lo;
    row_raddr    = q_data_i.lo;
    row_wdata    = row_lo_q + mmd_pkg::ROW_W'(new_sq_q) - mmd_pkg::ROW_W'(sq_q);
    div_start    = 1'b0;
    div_dividend = total_q;
    div_divisor  = nsq;

    case (state_q)
      S_CLEAR: begin
        dist_we    = 1'b1;
        dist_waddr = clr_q;
        dist_wdata = '0;
        row_we     = (clr_q < mmd_pkg::SLOT_W'(mmd_pkg::ATOM_MAX));
        row_waddr  = clr_q[mmd_pkg::IDX_W-1:0];
        row_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == mmd_pkg::SLOT_W'(mmd_pkg::PAIR_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          case (q_data_i.kind)
            mmd_pkg::KIND_WRITE: begin
              dist_re = 1'b1;
              row_re  = 1'b1;
              state_d = S_W1;
            end
            mmd_pkg::KIND_READ: begin
              dist_re = 1'b1;
              row_re  = 1'b1;
              state_d = S_R1;
            end
            default: begin
              res_d.metric_value = '0;
              res_d.status       = mmd_pkg::STATUS_RANGE;
              res_valid_d        = 1'b1;
            end
          endcase
        end
      end
      S_W1: begin
        sq_d      = mmd_pkg::SQ_W'(dist_rd_q) * mmd_pkg::SQ_W'(dist_rd_q);
        new_sq_d  = mmd_pkg::SQ_W'(cur_q.distance) * mmd_pkg::SQ_W'(cur_q.distance);
        row_lo_d  = row_rd_q;
        dist_we   = 1'b1;
        row_re    = 1'b1;
        row_raddr = cur_q.hi;
        state_d   = S_W2;
      end
      S_W2: begin
        row_we  = 1'b1;
        total_d = total_q + mmd_pkg::TOT_W'(new_sq_q) - mmd_pkg::TOT_W'(sq_q);
        state_d = S_W3;
      end
      S_W3: begin
        row_we    = 1'b1;
        row_waddr = cur_q.hi;
        row_wdata = row_rd_q + mmd_pkg::ROW_W'(new_sq_q) - mmd_pkg::ROW_W'(sq_q);
        state_d   = S_IDLE;
      end
      S_R1: begin
        sq_d      = mmd_pkg::SQ_W'(dist_rd_q) * mmd_pkg::SQ_W'(dist_rd_q);
        row_lo_d  = row_rd_q;
        row_re    = 1'b1;
        row_raddr = cur_q.hi;
        state_d   = S_R2;
      end
      S_R2: begin
        row_hi_d  = row_rd_q;
        div_start = 1'b1;
        state_d   = S_DT;
      end
      S_DT: begin
        div_dividend = {{(mmd_pkg::TOT_W - mmd_pkg::ROW_W){1'b0}}, row_lo_q};
        div_divisor  = n_ext;
        if (div_done) begin
          qt_d      = div_quot;
          div_start = 1'b1;
          state_d   = S_DL;
        end
      end
      S_DL: begin
        div_dividend = {{(mmd_pkg::TOT_W - mmd_pkg::ROW_W){1'b0}}, row_hi_q};
        div_divisor  = n_ext;
        if (div_done) begin
          ql_d = div_quot;
          if (cur_q.diag) begin
            state_d = S_F1;
          end else begin
            div_start = 1'b1;
            state_d   = S_DH;
          end
        end
      end
      S_DH: begin
        if (div_done) begin
          qh_d    = div_quot;
          state_d = S_F1;
        end
      end
      S_F1: begin
        di_d    = $signed({1'b0, ql_q}) - $signed({1'b0, qt_q});
        dj_d    = $signed({1'b0, qh_q}) - $signed({1'b0, qt_q});
        state_d = S_F2;
      end
      S_F2: begin
        sum_d   = cur_q.diag ? di_ext : di_ext + dj_ext - sq_ext;
        state_d = S_F3;
      end
      S_F3: begin
        if (half > VMAX) begin
          res_d.metric_value = VMAX[mmd_pkg::VAL_W-1:0];
        end else if (half < VMIN) begin
          res_d.metric_value = VMIN[mmd_pkg::VAL_W-1:0];
        end else begin
          res_d.metric_value = half[mmd_pkg::VAL_W-1:0];
        end
        res_d.status = mmd_pkg::STATUS_OK;
        res_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_re) begin
      dist_rd_q <= dist_mem[dist_raddr];
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    res_q    <= res_d;
    sq_q     <= sq_d;
    new_sq_q <= new_sq_d;
    row_lo_q <= row_lo_d;
    row_hi_q <= row_hi_d;
    qt_q     <= qt_d;
    ql_q     <= ql_d;
    qh_q     <= qh_d;
    di_q     <= di_d;
    dj_q     <= dj_d;
    sum_q    <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign clearing_o     = (state_q == S_CLEAR);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

[rtl/metric_matrix_from_distances.sv]
// Write: the back end runs states W1, W2 and W3 before it takes the next command.
// Read: three passes of the one radix-2 divider off the diagonal and two on it, each
//   on a 41-bit dividend; result strobes one cycle, 1 word per command.
// Bad read: range status, zero value. Up to two commands queue while one runs.
// After reset a clearing pass empties the distance and row-sum memories; busy is high
// during it. Results cannot be stalled.
module metric_matrix_from_distances (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  mmd_pkg::cmd_t             cmd_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mmd_pkg::CNT_W-1:0] cfg_data_i,
  output logic                      result_valid_o,
  output mmd_pkg::res_t             result_o
);

  logic                      push;
  logic                      pop;
  logic                      q_full;
  logic                      q_empty;
  logic                      clearing;
  mmd_pkg::cls_t             push_data;
  mmd_pkg::cls_t             pop_data;
  logic [mmd_pkg::CNT_W-1:0] n_eff;

  mmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .cmd_i       (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .cls_o       (push_data),
    .n_o         (n_eff)
  );

  mmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mmd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_i            (n_eff),
    .q_empty_i      (q_empty),
    .q_data_i       (pop_data),
    .q_pop_o        (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
